/* src/gbts_pkg.sv */
package gbts_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_RAMP  = 3'd2,
        PH_DWELL = 3'd3,
        PH_PAUSE = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        V_NONE = 3'd0,
        V_PASS = 3'd1,
        V_HIGH = 3'd2,
        V_LOW  = 3'd3,
        V_OPEN = 3'd4,
        V_OVER = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CHECK,
        CS_DIV,
        CS_EXEC
    } ctrl_state_t;

    localparam logic [2:0] REG_WAIT   = 3'd0;
    localparam logic [2:0] REG_RAMP   = 3'd1;
    localparam logic [2:0] REG_DWELL  = 3'd2;
    localparam logic [2:0] REG_PAUSE  = 3'd3;
    localparam logic [2:0] REG_TARGET = 3'd4;
    localparam logic [2:0] REG_HIGH   = 3'd5;
    localparam logic [2:0] REG_LOW    = 3'd6;
    localparam logic [2:0] REG_ALARM  = 3'd7;

    localparam logic [15:0] CUR_BAND_1   = 16'd4000;
    localparam logic [15:0] CUR_BAND_2   = 16'd7000;
    localparam logic [15:0] CUR_BAND_3   = 16'd10000;
    localparam logic [15:0] COMP_RES_HI  = 16'd500;
    localparam logic [15:0] COMP_RES_LO  = 16'd10;
    localparam logic [15:0] COMP_ADD_1   = 16'd60;
    localparam logic [15:0] COMP_ADD_2   = 16'd40;
    localparam logic [15:0] COMP_ADD_3   = 16'd20;
    localparam logic [15:0] OPEN_CUR_MAX = 16'd10;
    localparam logic [15:0] OPEN_RES     = 16'hFFFF;
    localparam logic [15:0] KEEP_WRAP    = 16'd10000;
    localparam logic [15:0] DWELL_GRACE  = 16'd7;

    typedef struct packed {
        logic [15:0] wait_ticks;
        logic [15:0] ramp_ticks;
        logic [15:0] dwell_ticks;
        logic [15:0] pause_ticks;
        logic [15:0] target_current;
        logic [12:0] res_high_limit;
        logic [12:0] res_low_limit;
        logic [12:0] alarm_voltage;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_test;
        logic div_busy;
    } dp_status_t;

    function automatic logic [16:0] times10(input logic [12:0] x);
        return {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
    endfunction

endpackage

/* src/ground_bond_test_sequencer.sv */
// Ground-bond test sequencer, advanced by one input beat per timer tick.
// The slave stream carries one tick of measurements; the master stream returns
// exactly one result beat for every input beat, in order.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. pready is always high and a read
// returns the stored register value. An ordinary tick passes through the check
// and execute states before its result is registered; a tick that starts a test
// also waits in the divide state for the ramp step, which a serial divider
// forms by resolving one quotient bit per cycle. One tick is worked on at a
// time; the next beat is accepted once the result of the previous one sits in
// the output register, even if that result has not been taken yet.
// When the receiver stalls, the result waits in the output register and the
// block holds off further input until the register can be reloaded.
// Reset returns the sequencer to idle, clears all counters and the stored
// offset, and loads the register defaults (wait of one tick, high limit 6553).
module ground_bond_test_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // stop_request, voltage_sample, current_sample, resistance_sample,
    // offset_apply, offset_capture, more_steps, zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase, current_setpoint, output_enable, elapsed_count, resistance_out,
    // verdict, zero fill
    output logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gbts_pkg::cfg_t       cfg_reg;
    gbts_pkg::cfg_t       cfg_next;
    gbts_pkg::ctrl_cmd_t  cmd;
    gbts_pkg::dp_status_t status;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                gbts_pkg::REG_WAIT:   cfg_next.wait_ticks     = pwdata[15:0];
                gbts_pkg::REG_RAMP:   cfg_next.ramp_ticks     = pwdata[15:0];
                gbts_pkg::REG_DWELL:  cfg_next.dwell_ticks    = pwdata[15:0];
                gbts_pkg::REG_PAUSE:  cfg_next.pause_ticks    = pwdata[15:0];
                gbts_pkg::REG_TARGET: cfg_next.target_current = pwdata[15:0];
                gbts_pkg::REG_HIGH:   cfg_next.res_high_limit = pwdata[12:0];
                gbts_pkg::REG_LOW:    cfg_next.res_low_limit  = pwdata[12:0];
                gbts_pkg::REG_ALARM:  cfg_next.alarm_voltage  = pwdata[12:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gbts_pkg::REG_WAIT:   prdata = {16'd0, cfg_reg.wait_ticks};
            gbts_pkg::REG_RAMP:   prdata = {16'd0, cfg_reg.ramp_ticks};
            gbts_pkg::REG_DWELL:  prdata = {16'd0, cfg_reg.dwell_ticks};
            gbts_pkg::REG_PAUSE:  prdata = {16'd0, cfg_reg.pause_ticks};
            gbts_pkg::REG_TARGET: prdata = {16'd0, cfg_reg.target_current};
            gbts_pkg::REG_HIGH:   prdata = {19'd0, cfg_reg.res_high_limit};
            gbts_pkg::REG_LOW:    prdata = {19'd0, cfg_reg.res_low_limit};
            gbts_pkg::REG_ALARM:  prdata = {19'd0, cfg_reg.alarm_voltage};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_ticks     <= 16'd1;
            cfg_reg.ramp_ticks     <= 16'd0;
            cfg_reg.dwell_ticks    <= 16'd0;
            cfg_reg.pause_ticks    <= 16'd0;
            cfg_reg.target_current <= 16'd0;
            cfg_reg.res_high_limit <= 13'd6553;
            cfg_reg.res_low_limit  <= 13'd0;
            cfg_reg.alarm_voltage  <= 13'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbts_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

/* src/gbts_div.sv */
module gbts_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] quo_reg;
    logic [15:0] quo_next;
    logic [15:0] dsr_reg;
    logic [15:0] dsr_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic [16:0] trial;

    assign trial = {rem_reg, quo_reg[15]};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* src/gbts_dp.sv */
module gbts_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbts_pkg::cfg_t        cfg,
    input  gbts_pkg::ctrl_cmd_t   cmd,
    output gbts_pkg::dp_status_t  status,
    input  logic [55:0]           in_data,
    output logic [55:0]           out_data
);

    // Latched input beat.
    logic        stop_q;
    logic [15:0] volt_q;
    logic [15:0] cur_q;
    logic [15:0] res_q;
    logic        oa_q;
    logic        oc_q;
    logic        more_q;

    gbts_pkg::phase_t phase_reg, phase_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [15:0] ramp_rem_reg, ramp_rem_next;
    logic [15:0] ramp_step_reg, ramp_step_next;
    logic [15:0] setpoint_reg, setpoint_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] pause_left_reg, pause_left_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] held_res_reg, held_res_next;
    logic [15:0] held_volt_reg, held_volt_next;
    logic [55:0] out_reg;
    logic [55:0] out_next;

    logic [15:0] divisor;
    logic        div_busy;
    logic [15:0] quotient;

    logic [16:0] high10;
    logic [16:0] low10;
    logic [16:0] alarm10;

    gbts_pkg::phase_t   ph;
    gbts_pkg::phase_t   nph;
    gbts_pkg::verdict_t verdict;
    gbts_pkg::verdict_t fault;
    logic [15:0] elapsed;
    logic [15:0] cnt;
    logic [15:0] cd_e;
    logic [15:0] rr_e;
    logic [15:0] sp_e;
    logic [15:0] tc_e;
    logic [15:0] hr_e;
    logic [15:0] hv_e;
    logic [15:0] res_ramp;
    logic [15:0] res_comp;
    logic [15:0] res_dwell;
    logic [15:0] comp_add;
    logic [18:0] cnt_x5;
    logic        enable;

    assign divisor = (cfg.ramp_ticks == 16'd0) ? 16'd1 : cfg.ramp_ticks;

    gbts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cfg.target_current),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.start_test = (phase_reg == gbts_pkg::PH_IDLE) && !stop_q;
    assign status.div_busy   = div_busy;

    assign high10  = gbts_pkg::times10(cfg.res_high_limit);
    assign low10   = gbts_pkg::times10(cfg.res_low_limit) + 17'd10;
    assign alarm10 = gbts_pkg::times10(cfg.alarm_voltage);

    function automatic logic is_high(input logic [15:0] r, input logic [16:0] lim10);
        return {1'b0, r} >= lim10;
    endfunction

    function automatic logic is_low(input logic [15:0] r, input logic [16:0] lim10p,
                                    input logic [12:0] lim);
        return (lim != 13'd0) && ({1'b0, r} < lim10p);
    endfunction

    function automatic logic is_over(input logic [15:0] v, input logic [16:0] al10,
                                     input logic [12:0] al);
        return (al != 13'd0) && ({1'b0, v} >= al10);
    endfunction

    function automatic logic [15:0] sub_off(input logic [15:0] r, input logic apply,
                                            input logic [15:0] off);
        logic [15:0] diff;
        diff = (r > off) ? (r - off) : 16'd0;
        return apply ? diff : r;
    endfunction

    always_comb
    begin
        priority if (cfg.target_current < gbts_pkg::CUR_BAND_1)
        begin
            comp_add = gbts_pkg::COMP_ADD_1;
        end
        else if (cfg.target_current < gbts_pkg::CUR_BAND_2)
        begin
            comp_add = gbts_pkg::COMP_ADD_2;
        end
        else if (cfg.target_current < gbts_pkg::CUR_BAND_3)
        begin
            comp_add = gbts_pkg::COMP_ADD_3;
        end
        else
        begin
            comp_add = 16'd0;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        countdown_next  = countdown_reg;
        ramp_rem_next   = ramp_rem_reg;
        ramp_step_next  = ramp_step_reg;
        setpoint_next   = setpoint_reg;
        tick_next       = tick_reg;
        pause_left_next = pause_left_reg;
        offset_next     = offset_reg;
        held_res_next   = held_res_reg;
        held_volt_next  = held_volt_reg;
        verdict         = gbts_pkg::V_NONE;
        fault           = gbts_pkg::V_NONE;
        elapsed         = 16'd0;
        ph              = phase_reg;
        nph             = phase_reg;
        cd_e            = countdown_reg;
        rr_e            = ramp_rem_reg;
        sp_e            = setpoint_reg;
        tc_e            = tick_reg;
        hr_e            = held_res_reg;
        hv_e            = held_volt_reg;
        cnt             = 16'd0;
        cnt_x5          = '0;
        res_ramp        = '0;
        res_comp        = '0;
        res_dwell       = '0;

        if (phase_reg == gbts_pkg::PH_DONE || (phase_reg == gbts_pkg::PH_IDLE && stop_q))
        begin
            phase_next    = gbts_pkg::PH_IDLE;
            setpoint_next = 16'd0;
            tick_next     = 16'd0;
        end
        else if (stop_q)
        begin
            phase_next    = gbts_pkg::PH_DONE;
            verdict       = gbts_pkg::V_PASS;
            setpoint_next = 16'd0;
            elapsed       = tick_reg;
            tick_next     = 16'd0;
        end
        else
        begin
            if (phase_reg == gbts_pkg::PH_IDLE)
            begin
                cd_e           = (cfg.wait_ticks == 16'd0) ? 16'd1 : cfg.wait_ticks;
                rr_e           = divisor;
                ramp_step_next = quotient;
                sp_e           = 16'd0;
                tc_e           = 16'd0;
                hr_e           = 16'd0;
                hv_e           = 16'd0;
                ph             = gbts_pkg::PH_WAIT;
            end
            countdown_next = cd_e;
            ramp_rem_next  = rr_e;
            setpoint_next  = sp_e;
            held_res_next  = hr_e;
            held_volt_next = hv_e;
            nph            = ph;
            cnt            = tc_e + 16'd1;
            cnt_x5         = {3'b000, cnt} + {1'b0, cnt, 2'b00};

            unique case (ph)
                gbts_pkg::PH_WAIT:
                begin
                    countdown_next = cd_e - 16'd1;
                    if (countdown_next == 16'd0)
                    begin
                        if (rr_e <= 16'd1)
                        begin
                            nph            = gbts_pkg::PH_DWELL;
                            setpoint_next  = cfg.target_current;
                            countdown_next = cfg.dwell_ticks;
                        end
                        else
                        begin
                            nph           = gbts_pkg::PH_RAMP;
                            setpoint_next = 16'd0;
                        end
                    end
                end
                gbts_pkg::PH_RAMP:
                begin
                    held_volt_next = volt_q;
                    ramp_rem_next  = rr_e - 16'd1;
                    if (ramp_rem_next == 16'd0)
                    begin
                        nph            = gbts_pkg::PH_DWELL;
                        setpoint_next  = cfg.target_current;
                        countdown_next = cfg.dwell_ticks;
                    end
                    else
                    begin
                        setpoint_next = sp_e + ramp_step_reg;
                    end
                    res_ramp      = sub_off(res_q, oa_q, offset_reg);
                    held_res_next = res_ramp;
                    if (cnt_x5 > {3'b000, cfg.ramp_ticks})
                    begin
                        if (cur_q <= gbts_pkg::OPEN_CUR_MAX)
                        begin
                            fault         = gbts_pkg::V_OPEN;
                            held_res_next = gbts_pkg::OPEN_RES;
                        end
                        else if (is_high(res_ramp, high10))
                        begin
                            fault = gbts_pkg::V_HIGH;
                        end
                    end
                    if (fault == gbts_pkg::V_NONE && is_over(volt_q, alarm10, cfg.alarm_voltage))
                    begin
                        fault = gbts_pkg::V_OVER;
                    end
                end
                gbts_pkg::PH_DWELL:
                begin
                    held_volt_next = volt_q;
                    res_comp = res_q;
                    if (res_q < gbts_pkg::COMP_RES_HI && res_q > gbts_pkg::COMP_RES_LO)
                    begin
                        res_comp = res_q + comp_add;
                    end
                    if (cd_e == 16'd0)
                    begin
                        if (tc_e >= gbts_pkg::KEEP_WRAP)
                        begin
                            cnt = 16'd1;
                        end
                    end
                    else
                    begin
                        countdown_next = cd_e - 16'd1;
                        if (countdown_next == 16'd0)
                        begin
                            if (cfg.pause_ticks != 16'd0 && more_q)
                            begin
                                nph             = gbts_pkg::PH_PAUSE;
                                pause_left_next = cfg.pause_ticks;
                            end
                            else
                            begin
                                nph     = gbts_pkg::PH_DONE;
                                verdict = gbts_pkg::V_PASS;
                            end
                            setpoint_next = 16'd0;
                        end
                    end
                    held_res_next = res_comp;
                    if (nph == gbts_pkg::PH_DWELL)
                    begin
                        res_dwell     = sub_off(res_comp, oa_q, offset_reg);
                        held_res_next = res_dwell;
                        if (cnt > gbts_pkg::DWELL_GRACE)
                        begin
                            priority if (cur_q <= gbts_pkg::OPEN_CUR_MAX)
                            begin
                                fault         = gbts_pkg::V_OPEN;
                                held_res_next = gbts_pkg::OPEN_RES;
                            end
                            else if (is_high(res_dwell, high10))
                            begin
                                fault = gbts_pkg::V_HIGH;
                            end
                            else if (is_low(res_dwell, low10, cfg.res_low_limit))
                            begin
                                fault = gbts_pkg::V_LOW;
                            end
                            else if (is_over(volt_q, alarm10, cfg.alarm_voltage))
                            begin
                                fault = gbts_pkg::V_OVER;
                            end
                            else
                            begin
                                fault = gbts_pkg::V_NONE;
                            end
                        end
                        if (oc_q && fault != gbts_pkg::V_OPEN)
                        begin
                            offset_next = res_dwell;
                        end
                    end
                end
                default:
                begin
                    if (is_high(hr_e, high10))
                    begin
                        fault = gbts_pkg::V_HIGH;
                    end
                    else if (is_over(hv_e, alarm10, cfg.alarm_voltage))
                    begin
                        fault = gbts_pkg::V_OVER;
                    end
                    pause_left_next = pause_left_reg - 16'd1;
                    if (pause_left_next == 16'd0)
                    begin
                        nph     = gbts_pkg::PH_DONE;
                        verdict = gbts_pkg::V_PASS;
                    end
                end
            endcase

            if (fault != gbts_pkg::V_NONE)
            begin
                nph     = gbts_pkg::PH_DONE;
                verdict = fault;
            end
            if (nph == gbts_pkg::PH_DONE)
            begin
                setpoint_next = 16'd0;
            end
            elapsed    = cnt;
            tick_next  = (nph != ph) ? 16'd0 : cnt;
            phase_next = nph;
        end

        enable   = (phase_next >= gbts_pkg::PH_WAIT) && (phase_next <= gbts_pkg::PH_PAUSE);
        out_next = {1'b0, verdict, held_res_next, elapsed, enable, setpoint_next, phase_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= gbts_pkg::PH_IDLE;
            countdown_reg  <= '0;
            ramp_rem_reg   <= '0;
            ramp_step_reg  <= '0;
            setpoint_reg   <= '0;
            tick_reg       <= '0;
            pause_left_reg <= '0;
            offset_reg     <= '0;
            held_res_reg   <= '0;
            held_volt_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg      <= phase_next;
            countdown_reg  <= countdown_next;
            ramp_rem_reg   <= ramp_rem_next;
            ramp_step_reg  <= ramp_step_next;
            setpoint_reg   <= setpoint_next;
            tick_reg       <= tick_next;
            pause_left_reg <= pause_left_next;
            offset_reg     <= offset_next;
            held_res_reg   <= held_res_next;
            held_volt_reg  <= held_volt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stop_q <= in_data[0];
            volt_q <= in_data[16:1];
            cur_q  <= in_data[32:17];
            res_q  <= in_data[48:33];
            oa_q   <= in_data[49];
            oc_q   <= in_data[50];
            more_q <= in_data[51];
        end
        if (cmd.exec)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

/* src/gbts_ctrl.sv */
module gbts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  gbts_pkg::dp_status_t  status,
    output gbts_pkg::ctrl_cmd_t   cmd
);

    gbts_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbts_pkg::CS_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = gbts_pkg::CS_CHECK;
                end
            end
            gbts_pkg::CS_CHECK:
            begin
                state_next = status.start_test ? gbts_pkg::CS_DIV : gbts_pkg::CS_EXEC;
            end
            gbts_pkg::CS_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = gbts_pkg::CS_EXEC;
                end
            end
            gbts_pkg::CS_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = gbts_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = gbts_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == gbts_pkg::CS_IDLE);
        cmd.capture   = s_tready && s_tvalid;
        cmd.div_start = (state_reg == gbts_pkg::CS_CHECK) && status.start_test;
        cmd.exec      = (state_reg == gbts_pkg::CS_EXEC) && slot_free;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbts_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
